/* rtl/fixed_point_alu_24_8_defines.svh */
// Assertion macros for the Q24.8 ALU.
// Used by the top level only; no other dependencies.
`ifndef FIXED_POINT_ALU_24_8_DEFINES_SVH
`define FIXED_POINT_ALU_24_8_DEFINES_SVH
`ifndef SYNTHESIS
`define FPA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FPA_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPA_ASSERT(label, clk, rstn, prop, msg)
`define FPA_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* rtl/fpa_pkg.sv */
// Shared opcodes, widths and the decoded command word for the Q24.8 ALU.
// No dependencies.
package fpa_pkg;
    localparam int unsigned DataW = 32;
    localparam int unsigned OpW   = 4;

    localparam logic [OpW-1:0] OP_ADD  = 4'd0;
    localparam logic [OpW-1:0] OP_SUB  = 4'd1;
    localparam logic [OpW-1:0] OP_MUL  = 4'd2;
    localparam logic [OpW-1:0] OP_DIV  = 4'd3;
    localparam logic [OpW-1:0] OP_GT   = 4'd4;
    localparam logic [OpW-1:0] OP_LT   = 4'd5;
    localparam logic [OpW-1:0] OP_GE   = 4'd6;
    localparam logic [OpW-1:0] OP_LE   = 4'd7;
    localparam logic [OpW-1:0] OP_EQ   = 4'd8;
    localparam logic [OpW-1:0] OP_NE   = 4'd9;
    localparam logic [OpW-1:0] OP_FINT = 4'd10;
    localparam logic [OpW-1:0] OP_TINT = 4'd11;

    // unit selected by the front end
    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_FAST = 2'd1,
        CLS_MUL  = 2'd2,
        CLS_DIV  = 2'd3
    } cls_t;

    typedef struct packed {
        cls_t             cls;
        logic [OpW-1:0]   op;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
    } cmd_t;
endpackage

/* rtl/fpa_front.sv */
// Front end: accept words, classify the opcode, push into the command queue.
// Depends on fpa_pkg.
module fpa_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [fpa_pkg::OpW-1:0]     s_op,
    input  logic signed [fpa_pkg::DataW-1:0] s_operand_a,
    input  logic signed [fpa_pkg::DataW-1:0] s_operand_b,
    output logic                        q_valid,
    input  logic                        q_ready,
    output fpa_pkg::cmd_t               q_cmd
);
    // two-entry queue
    fpa_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg;
    fpa_pkg::cmd_t cmd;
    logic          push, pop;

    always_comb begin
        cmd.op = s_op;
        cmd.a  = s_operand_a;
        cmd.b  = s_operand_b;
        case (s_op)
            fpa_pkg::OP_MUL: cmd.cls = fpa_pkg::CLS_MUL;
            fpa_pkg::OP_DIV: cmd.cls = fpa_pkg::CLS_DIV;
            default: begin
                if (s_op inside {[fpa_pkg::OP_ADD:fpa_pkg::OP_TINT]}) cmd.cls = fpa_pkg::CLS_FAST;
                else cmd.cls = fpa_pkg::CLS_NONE;
            end
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_cmd   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* rtl/fpa_div.sv */
// Pipelined signed divider: one quotient bit per stage, magnitude restoring.
// Depends on fpa_pkg. Takes one word per cycle while en is high.
module fpa_div #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [fpa_pkg::DataW-1:0] a,
    input  logic [fpa_pkg::DataW-1:0] b,
    output logic                     out_valid,
    output logic [fpa_pkg::DataW-1:0] quot
);
    localparam int unsigned W    = fpa_pkg::DataW;
    localparam int unsigned NumW = W + FRAC_BITS;

    logic [NumW-1:0] num_reg [NumW+1];
    logic [W-1:0]    den_reg [NumW+1];
    logic [W:0]      rem_reg [NumW+1];
    logic            neg_reg [NumW+1];
    logic            vld_reg [NumW+1];

    logic [W-1:0]    a_mag, b_mag;
    logic [NumW-1:0] num_mag;

    assign a_mag   = a[W-1] ? (~a + 1'b1) : a;
    assign b_mag   = b[W-1] ? (~b + 1'b1) : b;
    assign num_mag = {a_mag, {FRAC_BITS{1'b0}}};

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg[0] <= num_mag;
            den_reg[0] <= b_mag;
            rem_reg[0] <= '0;
            neg_reg[0] <= a[W-1] ^ b[W-1];
        end
    end

    for (genvar i = 0; i < NumW; i++) begin : g_stage
        logic [W:0] trial;
        logic [W:0] diff;
        assign trial = {rem_reg[i][W-1:0], num_reg[i][NumW-1]};
        assign diff  = trial - {1'b0, den_reg[i]};
        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[i+1] <= den_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                rem_reg[i+1] <= diff[W] ? trial : diff;
                // shift the quotient bit into the vacated low end
                num_reg[i+1] <= {num_reg[i][NumW-2:0], ~diff[W]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NumW; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int k = 0; k < NumW; k++) vld_reg[k+1] <= vld_reg[k];
        end
    end

    assign out_valid = vld_reg[NumW];
    assign quot = neg_reg[NumW] ? (~num_reg[NumW][W-1:0] + 1'b1) : num_reg[NumW][W-1:0];
endmodule

/* rtl/fpa_back.sv */
// Back end: executes commands in a fixed-latency pipeline with an output register.
// Depends on fpa_pkg and fpa_div.
module fpa_back #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  fpa_pkg::cmd_t               q_cmd,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [fpa_pkg::DataW-1:0] m_result_value,
    output logic                        m_compare_true,
    output logic                        m_div_by_zero
);
    localparam int unsigned W    = fpa_pkg::DataW;
    localparam int unsigned Lat  = W + FRAC_BITS + 1;

    typedef struct packed {
        fpa_pkg::cls_t cls;
        logic [W-1:0]  res;
        logic          cmp;
        logic          dz;
    } tag_t;

    // pipeline advances when its output slot is free
    logic en;
    assign en      = !m_valid || m_ready;
    assign q_ready = en;

    logic in_v;
    assign in_v = q_valid && en;

    logic signed [W-1:0] sa, sb;
    assign sa = q_cmd.a;
    assign sb = q_cmd.b;

    tag_t tag;
    always_comb begin
        tag.cls = q_cmd.cls;
        tag.res = '0;
        tag.cmp = 1'b0;
        tag.dz  = 1'b0;
        case (q_cmd.op)
            fpa_pkg::OP_ADD:  tag.res = q_cmd.a + q_cmd.b;
            fpa_pkg::OP_SUB:  tag.res = q_cmd.a - q_cmd.b;
            fpa_pkg::OP_DIV:  tag.dz  = (q_cmd.b == '0);
            fpa_pkg::OP_GT:   tag.cmp = sa > sb;
            fpa_pkg::OP_LT:   tag.cmp = sa < sb;
            fpa_pkg::OP_GE:   tag.cmp = sa >= sb;
            fpa_pkg::OP_LE:   tag.cmp = sa <= sb;
            fpa_pkg::OP_EQ:   tag.cmp = sa == sb;
            fpa_pkg::OP_NE:   tag.cmp = sa != sb;
            fpa_pkg::OP_FINT: tag.res = q_cmd.a << FRAC_BITS;
            fpa_pkg::OP_TINT: tag.res = W'(sa >>> FRAC_BITS);
            default: ;
        endcase
    end

    tag_t tag_reg [Lat];

    // multiplier: product registered, then shifted into a delay line to the tail
    logic signed [2*W-1:0] prod_reg;
    logic [W-1:0]          mulres_reg [Lat-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= sa * sb;
            tag_reg[0] <= tag;
            for (int k = 1; k < Lat; k++) tag_reg[k] <= tag_reg[k-1];
            mulres_reg[0] <= W'(prod_reg >>> FRAC_BITS);
            for (int k = 1; k < Lat-1; k++) mulres_reg[k] <= mulres_reg[k-1];
        end
    end

    // the divider carries the valid bit for the whole pipeline
    logic         dv;
    logic [W-1:0] quot;
    fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(in_v),
        .a(q_cmd.a), .b(q_cmd.b), .out_valid(dv), .quot(quot)
    );

    tag_t         t;
    logic [W-1:0] res_next;
    assign t = tag_reg[Lat-1];
    always_comb begin
        case (t.cls)
            fpa_pkg::CLS_MUL: res_next = mulres_reg[Lat-2];
            fpa_pkg::CLS_DIV: res_next = t.dz ? '0 : quot;
            default:          res_next = t.res;
        endcase
    end

    logic         m_valid_reg;
    logic [W-1:0] m_res_reg;
    logic         m_cmp_reg, m_dz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            m_res_reg <= res_next;
            m_cmp_reg <= t.cmp;
            m_dz_reg  <= t.dz;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_res_reg;
    assign m_compare_true = m_cmp_reg;
    assign m_div_by_zero  = m_dz_reg;
endmodule

/* rtl/fixed_point_alu_24_8.sv */
// Q24.8 fixed-point ALU: add, sub, mul, div, compares, int conversions.
// Usage: push words on s_* (op, operand_a, operand_b); take results on m_*.
// Each input word gives exactly one result word, in order.
// Front end classifies the opcode into a two-entry queue; the back end is a
// fixed pipeline of FRAC_BITS+34 stages set by the bit-per-stage divider.
// Throughput: one word per cycle while m_ready stays high.
// When the receiver stalls the whole back pipeline holds; the queue absorbs
// up to two words, then s_ready drops.
// Divide by zero returns 0 with m_div_by_zero set; compares return 0 in
// m_result_value and the outcome in m_compare_true.
// Synchronous active-low reset empties the queue and pipeline; no words are
// in flight afterwards.
// Depends on fpa_pkg, fpa_front, fpa_back, fpa_div and the defines header.
`include "fixed_point_alu_24_8_defines.svh"
module fixed_point_alu_24_8 #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [fpa_pkg::OpW-1:0]          s_op,
    input  logic signed [fpa_pkg::DataW-1:0] s_operand_a,
    input  logic signed [fpa_pkg::DataW-1:0] s_operand_b,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [fpa_pkg::DataW-1:0] m_result_value,
    output logic                             m_compare_true,
    output logic                             m_div_by_zero
);
    logic          q_valid, q_ready;
    fpa_pkg::cmd_t q_cmd;

    fpa_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_value(m_result_value),
        .m_compare_true(m_compare_true), .m_div_by_zero(m_div_by_zero)
    );

    `FPA_ASSERT(a_flags_excl, aclk, aresetn, m_valid |-> !(m_compare_true && m_div_by_zero), "compare and div-by-zero both set")
    `FPA_ASSERT(a_dz_zero, aclk, aresetn, (m_valid && m_div_by_zero) |-> (m_result_value == '0), "div by zero with nonzero result")
    `FPA_ASSERT_RST(a_rst_empty, aclk, !aresetn |=> !m_valid, "result valid right after reset")
endmodule
